// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// ----- design/mlfd_pkg.sv -----
package mlfd_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned CNT_W     = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN      = 2'd2;

  localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

  // Controller to datapath
  typedef struct packed {
    logic push;        // append accepted byte to header window
    logic drop;        // discard front byte of header window
    logic load_hdr;    // latch type/length, clear window
    logic emit_empty;  // issue empty-body result
    logic emit_body;   // issue body byte result
  } mlfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic win_bad;   // window cannot start a frame
    logic win_full;  // eight header bytes present
    logic len_over;  // header length above limit
    logic len_zero;  // header length is zero
    logic rem_last;  // current body byte is the final one
    logic out_free;  // output register can take a result this cycle
  } mlfd_sts_t;

endpackage

// ----- design/mlfd_dp.sv -----
module mlfd_dp
  import mlfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic [7:0]  rx_byte,
  input  mlfd_cmd_t   cmd,
  output mlfd_sts_t   sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic        out_tlast,
  output logic [0:0]  out_tuser
);

  logic [7:0]       magic_first_r;
  logic [7:0]       magic_second_r;
  logic [31:0]      max_len_r;
  logic [7:0]       win_r [HDR_BYTES];
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      rem_r;
  logic [15:0]      cur_type_r;
  logic [31:0]      cur_len_r;
  logic             ov_r;
  logic [55:0]      od_r;
  logic             ol_r;
  logic             oe_r;
  logic [15:0]      hdr_type;
  logic [31:0]      hdr_len;

  assign hdr_type = {win_r[2], win_r[3]};
  assign hdr_len  = {win_r[4], win_r[5], win_r[6], win_r[7]};

  // Status toward the controller
  always_comb begin
    sts.win_bad  = (cnt_r != '0) && ((win_r[0] != magic_first_r) ||
                   ((cnt_r >= CNT_W'(2)) && (win_r[1] != magic_second_r)));
    sts.win_full = (cnt_r == CNT_W'(HDR_BYTES));
    sts.len_over = (hdr_len > max_len_r);
    sts.len_zero = (hdr_len == '0);
    sts.rem_last = (rem_r <= 32'd1);
    sts.out_free = !ov_r || out_tready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= '0;
      magic_second_r <= '0;
      max_len_r      <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAGIC_FIRST:  magic_first_r  <= cfg_wdata[7:0];
        CFG_MAGIC_SECOND: magic_second_r <= cfg_wdata[7:0];
        CFG_MAX_LEN:      max_len_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Header window: append at fill level, shift down on drop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_r[cnt_r[2:0]] <= rx_byte;
    end else if (cmd.drop) begin
      for (int i = 0; i < HDR_BYTES - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
  end

  // Window fill level and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rem_r      <= '0;
      cur_type_r <= '0;
      cur_len_r  <= '0;
    end else begin
      if (cmd.push) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.drop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end else if (cmd.load_hdr) begin
        cnt_r <= '0;
      end
      if (cmd.load_hdr) begin
        cur_type_r <= hdr_type;
        cur_len_r  <= hdr_len;
        rem_r      <= hdr_len;
      end else if (cmd.emit_body && (rem_r != '0)) begin
        rem_r <= rem_r - 32'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_body || cmd.emit_empty) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      od_r <= {8'd0, 32'd0, hdr_type};
      ol_r <= 1'b1;
      oe_r <= 1'b1;
    end else if (cmd.emit_body) begin
      od_r <= {rx_byte, cur_len_r, cur_type_r};
      ol_r <= sts.rem_last;
      oe_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = oe_r;

endmodule

// ----- design/mlfd_ctrl.sv -----
module mlfd_ctrl
  import mlfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  mlfd_sts_t sts,
  output mlfd_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_SCAN,
    ST_BODY
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Handshake and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_HUNT: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.push  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts.win_bad) begin
          cmd.drop = 1'b1;
        end else if (!sts.win_full) begin
          state_nxt = ST_HUNT;
        end else if (sts.len_over) begin
          cmd.drop = 1'b1;
        end else if (!sts.len_zero) begin
          cmd.load_hdr = 1'b1;
          state_nxt    = ST_BODY;
        end else if (sts.out_free) begin
          cmd.load_hdr   = 1'b1;
          cmd.emit_empty = 1'b1;
          state_nxt      = ST_HUNT;
        end else begin
          // hold until the output register drains
        end
      end
      ST_BODY: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          cmd.emit_body = 1'b1;
          if (sts.rem_last) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/magic_length_frame_deframer.sv -----
// Output: a body byte is registered and appears on the output in the cycle after its transfer.
// Throughput: body bytes at one per cycle while the output register can take them; a header
//   byte is taken in ST_HUNT, then the window is scanned in ST_SCAN (one byte dropped per cycle).
// The scan cost is set by the single-step header window shifter.
// Reset: synchronous active-low rst_n clears control state and config registers.
`include "assert_macros.svh"

module magic_length_frame_deframer
  import mlfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] msg_type, [47:16] body_length, [55:48] body_byte
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] empty_body
);

  mlfd_cmd_t cmd;
  mlfd_sts_t sts;

  mlfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlfd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // An empty-body result is always the last of its frame with zero length and data
  `ASSERT_IMPLIES(a_empty_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast && (out_tdata[55:16] == 40'd0))
  // A full window is never appended to
  `ASSERT_IMPLIES(a_full_no_push, clk, rst_n, sts.win_full, !cmd.push)
  // Push never coincides with drop or header load
  `ASSERT_IMPLIES(a_push_drop, clk, rst_n, cmd.push, !cmd.drop && !cmd.load_hdr)
  // A result is only issued into a free output register
  `ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.emit_body || cmd.emit_empty, sts.out_free)

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfd_pkg::*;

  // Address that decodes to no register
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // Cycles allowed for the window scan to finish after the last transfer
  localparam int SCAN_SLACK = 16;
  localparam int REPORT_LIMIT = 10;

  // One output transfer, unpacked from tdata/tlast/tuser
  typedef struct packed {
    logic [15:0] msg_type;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        is_last;
    logic        is_empty;
  } frame_beat_t;

  // Tracks header hunting and body forwarding, and holds the beats still due
  class deframer_scoreboard;
    logic [7:0]  magic_a;
    logic [7:0]  magic_b;
    logic [31:0] len_limit;
    logic [7:0]  hdr[HDR_BYTES];
    int unsigned hdr_count;
    bit          in_body;
    logic [31:0] body_left;
    logic [15:0] frame_type;
    logic [31:0] frame_len;
    frame_beat_t due_beats[$];
    int unsigned mismatches;

    function new();
      magic_a    = '0;
      magic_b    = '0;
      len_limit  = MAX_LEN_RESET;
      hdr_count  = 0;
      in_body    = 1'b0;
      body_left  = '0;
      frame_type = '0;
      frame_len  = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MAGIC_FIRST:  magic_a = val[7:0];
        CFG_MAGIC_SECOND: magic_b = val[7:0];
        CFG_MAX_LEN:      len_limit = val;
        default: ;
      endcase
    endfunction

    // True when nothing is buffered: safe point for register writes
    function bit idle_state();
      return !in_body && hdr_count == 0;
    endfunction

    function bit prefix_ok();
      if (hdr_count == 0) return 1'b1;
      if (hdr[0] != magic_a) return 1'b0;
      return hdr_count < 2 || hdr[1] == magic_b;
    endfunction

    function void shift_hdr();
      for (int i = 1; i < hdr_count; i++) hdr[i-1] = hdr[i];
      hdr_count--;
    endfunction

    // Accepted input byte: update state and queue any resulting beat
    function void note_byte(logic [7:0] b);
      frame_beat_t beat;
      logic [31:0] len;
      if (in_body) begin
        beat.msg_type    = frame_type;
        beat.body_length = frame_len;
        beat.body_byte   = b;
        beat.is_last     = body_left <= 1;
        beat.is_empty    = 1'b0;
        due_beats.push_back(beat);
        if (body_left > 0) body_left--;
        if (body_left == 0) in_body = 1'b0;
        return;
      end
      if (hdr_count < HDR_BYTES) begin
        hdr[hdr_count] = b;
        hdr_count++;
      end
      // oversized headers drop one byte and rescan, at most once per window byte
      for (int guard = 0; guard <= HDR_BYTES; guard++) begin
        while (hdr_count > 0 && !prefix_ok()) shift_hdr();
        if (hdr_count < HDR_BYTES) return;
        len = {hdr[4], hdr[5], hdr[6], hdr[7]};
        if (len > len_limit) begin
          shift_hdr();
          continue;
        end
        frame_type = {hdr[2], hdr[3]};
        frame_len  = len;
        hdr_count  = 0;
        if (len == 0) begin
          beat.msg_type    = frame_type;
          beat.body_length = '0;
          beat.body_byte   = '0;
          beat.is_last     = 1'b1;
          beat.is_empty    = 1'b1;
          due_beats.push_back(beat);
        end else begin
          in_body   = 1'b1;
          body_left = len;
        end
        return;
      end
    endfunction

    // Output transfer: compare against the oldest beat still due
    function void check_result(frame_beat_t got);
      frame_beat_t want;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: output transfer with nothing due: type %h len %h byte %h last %b empty %b",
                   $realtime, got.msg_type, got.body_length, got.body_byte, got.is_last,
                   got.is_empty);
        return;
      end
      want = due_beats.pop_front();
      if (got.msg_type !== want.msg_type || got.body_length !== want.body_length ||
          got.body_byte !== want.body_byte || got.is_last !== want.is_last ||
          got.is_empty !== want.is_empty) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch (exp/got) type %h/%h len %h/%h byte %h/%h last %b/%b empty %b/%b",
                   $realtime,
                   want.msg_type, got.msg_type, want.body_length, got.body_length,
                   want.body_byte, got.body_byte, want.is_last, got.is_last,
                   want.is_empty, got.is_empty);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  deframer_scoreboard sb = new();
  int unsigned bytes_sent;
  bit          steady;  // no input gaps while set

  magic_length_frame_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short idle gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Output backpressure
  initial begin : sink_stall
    int unsigned hold;
    out_tready <= 1'b0;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (hold) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Output monitor; tdata = {body_byte, body_length, msg_type}, tuser[0] = empty_body
  always @(posedge clk) begin
    frame_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.msg_type    = out_tdata[15:0];
      got.body_length = out_tdata[47:16];
      got.body_byte   = out_tdata[55:48];
      got.is_last     = out_tlast;
      got.is_empty    = out_tuser[0];
      sb.check_result(got);
    end
  end

  // One byte transfer; leaves tvalid high so back-to-back bytes need no extra edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic send_header(input logic [15:0] ftype, input logic [31:0] flen);
    logic [63:0] bytes;
    bytes = {sb.magic_a, sb.magic_b, ftype, flen};
    for (int i = HDR_BYTES - 1; i >= 0; i--) send_byte(bytes[i*8 +: 8]);
  endtask

  // Well-formed frame; an oversized header gets no body since it is skipped
  task automatic send_frame(input logic [15:0] ftype, input logic [31:0] flen);
    send_header(ftype, flen);
    if (flen <= sb.len_limit)
      repeat (flen) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise(input bit clean);
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = 8'($urandom_range(0, 255));
      while (clean && b == sb.magic_a) b = 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  // Lone first magic byte, or a header cut short
  task automatic send_broken();
    send_byte(sb.magic_a);
    if ($urandom_range(0, 1) == 1) begin
      send_byte(sb.magic_b);
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [31:0] pick_len(input logic [31:0] lim, input bit clean);
    int unsigned r;
    logic [31:0] cap;
    r   = $urandom_range(0, 99);
    cap = (lim < 24) ? lim : 32'd24;
    if (r < 12) return '0;
    if (r < 22 && lim <= 600) return lim;
    if (r < 34 && !clean && lim != 32'hFFFF_FFFF)
      return ($urandom_range(0, 1) == 1) ? lim + 1 : $urandom_range(32'hFFFF_FFFF, lim + 1);
    if (cap == 0) return clean ? 32'd0 : 32'($urandom_range(1, 24));
    return $urandom_range(1, cap);
  endfunction

  // Flush any partial header or body with a non-magic pad byte, then drain
  task automatic settle();
    logic [7:0] pad;
    pad    = ~sb.magic_a;
    steady = 1'b0;
    while (!sb.idle_state()) send_byte(pad);
    in_tvalid <= 1'b0;
    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (SCAN_SLACK) @(posedge clk);
  endtask

  // clean: only well-formed frames and non-magic noise, so huge limits stay bounded
  task automatic run_phase(input logic [7:0] m1, input logic [7:0] m2,
                           input logic [31:0] lim, input bit clean,
                           input int unsigned budget);
    logic [31:0] junk;
    int unsigned stop_at;
    int unsigned r;
    junk = $urandom();
    write_reg(CFG_MAGIC_FIRST, {junk[31:8], m1});
    junk = $urandom();
    write_reg(CFG_MAGIC_SECOND, {junk[31:8], m2});
    write_reg(CFG_MAX_LEN, lim);
    cfg_we <= 1'b0;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70)
        send_frame(16'($urandom()), pick_len(lim, clean));
      else if (r < 85 || clean)
        send_noise(clean);
      else
        send_broken();
    end
    settle();
  endtask

  initial begin : stimulus
    logic [7:0] m;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    steady     = 1'b0;
    bytes_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: empty body with all-ones type
    send_frame(16'hFFFF, 32'd0);
    // two-byte body with zero type, body bytes at both extremes
    send_header(16'h0000, 32'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    // stray byte, then a lone first magic byte broken by a non-magic one
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    settle();

    // Random phases across register settings
    run_phase(8'hA5, 8'h5A, 32'd0, 1'b0, 60);
    write_reg(CFG_UNUSED, $urandom());
    run_phase(8'hFF, 8'hFF, 32'd32, 1'b0, 75);
    run_phase(8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b1, 75);
    m = 8'($urandom_range(0, 255));
    run_phase(m, m, $urandom_range(1, 48), 1'b0, 75);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              $urandom_range(0, 64), 1'b0, 75);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              $urandom_range(0, 64), 1'b0, 75);
    run_phase(8'h7E, 8'h81, 32'd300, 1'b0, 75);

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- magic_length_frame_deframer.f -----
+incdir+design
design/mlfd_pkg.sv
design/mlfd_dp.sv
design/mlfd_ctrl.sv
design/magic_length_frame_deframer.sv
tb/testbench.sv
